// ===== rtl/bsa_pkg.sv =====
// Shared types and constants of the banker's safety allocator.
// No dependencies; bsa_scan and the top level import this package.
package bsa_pkg;

    localparam logic [1:0] KIND_DECLARE = 2'd0;
    localparam logic [1:0] KIND_REQUEST = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    localparam logic [2:0] ST_GRANTED    = 3'd0;
    localparam logic [2:0] ST_OVER_CLAIM = 3'd1;
    localparam logic [2:0] ST_OVER_AVAIL = 3'd2;
    localparam logic [2:0] ST_UNSAFE     = 3'd3;
    localparam logic [2:0] ST_DONE       = 3'd4;
    localparam logic [2:0] ST_INVALID    = 3'd5;

    localparam int MAX_TYPES = 3;

    localparam logic [MAX_TYPES-1:0][7:0] TOTAL_RESET = {8'd7, 8'd5, 8'd10};

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_LOOKUP = 3'b010,
        S_SCAN   = 3'b100
    } state_t;

    typedef struct packed {
        logic done;
        logic safe;
    } scan_stat_t;

endpackage

// ===== rtl/bsa_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module bsa_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/bsa_scan.sv =====
// Safety check engine: repeated passes over the process table held in RAM.
// Depends on bsa_pkg; reads the table through the read port of bsa_ram.
module bsa_scan
    import bsa_pkg::*;
#(
    parameter int NUM_PROC   = 8,
    parameter int COUNT_BITS = 8,
    parameter int NUM_TYPES  = 3
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic [NUM_TYPES-1:0][COUNT_BITS-1:0]      work_init,
    input  logic [$clog2(NUM_PROC)-1:0]               tent_idx,
    input  logic [NUM_TYPES-1:0][COUNT_BITS-1:0]      tent_hold,
    input  logic [2*NUM_TYPES*COUNT_BITS-1:0]         rd_word,
    output logic [$clog2(NUM_PROC)-1:0]               rd_addr,
    output scan_stat_t                                stat
);

    localparam int AW = $clog2(NUM_PROC);
    localparam int CB = COUNT_BITS;
    localparam logic [AW-1:0] LAST = AW'(NUM_PROC - 1);

    logic                          issue_on_reg, issue_on_next;
    logic [AW-1:0]                 pass_reg, pass_next;
    logic [AW-1:0]                 proc_reg, proc_next;
    logic                          eval_vld_reg, eval_vld_next;
    logic [AW-1:0]                 eval_idx_reg, eval_idx_next;
    logic [NUM_TYPES-1:0][CB-1:0]  work_reg, work_next;
    logic [NUM_PROC-1:0]           fin_reg, fin_next;
    logic                          done_reg, done_next;
    logic [NUM_TYPES-1:0][CB-1:0]  ev_claim;
    logic [NUM_TYPES-1:0][CB-1:0]  ev_hold;
    logic                          fits;

    assign rd_addr   = proc_reg;
    assign stat.done = done_reg;
    assign stat.safe = &fin_reg;

    always_comb
    begin
        issue_on_next = issue_on_reg;
        pass_next     = pass_reg;
        proc_next     = proc_reg;
        eval_vld_next = issue_on_reg;
        eval_idx_next = proc_reg;
        work_next     = work_reg;
        fin_next      = fin_reg;
        done_next     = eval_vld_reg && !issue_on_reg;

        for (int t = 0; t < NUM_TYPES; t++)
        begin
            ev_claim[t] = rd_word[t*CB +: CB];
            ev_hold[t]  = (eval_idx_reg == tent_idx) ? tent_hold[t]
                                                    : rd_word[(NUM_TYPES+t)*CB +: CB];
        end

        fits = eval_vld_reg && !fin_reg[eval_idx_reg];
        for (int t = 0; t < NUM_TYPES; t++)
        begin
            if ((ev_claim[t] - ev_hold[t]) > work_reg[t])
            begin
                fits = 1'b0;
            end
        end

        if (fits)
        begin
            for (int t = 0; t < NUM_TYPES; t++)
            begin
                work_next[t] = work_reg[t] + ev_hold[t];
            end
            fin_next[eval_idx_reg] = 1'b1;
        end

        if (issue_on_reg)
        begin
            if (proc_reg == LAST)
            begin
                proc_next = '0;
                pass_next = pass_reg + 1'b1;
                if (pass_reg == LAST)
                begin
                    issue_on_next = 1'b0;
                end
            end
            else
            begin
                proc_next = proc_reg + 1'b1;
            end
        end

        if (start)
        begin
            issue_on_next = 1'b1;
            pass_next     = '0;
            proc_next     = '0;
            eval_vld_next = 1'b0;
            work_next     = work_init;
            fin_next      = '0;
            done_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_on_reg <= 1'b0;
            pass_reg     <= '0;
            proc_reg     <= '0;
            eval_vld_reg <= 1'b0;
            eval_idx_reg <= '0;
            work_reg     <= '0;
            fin_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            issue_on_reg <= issue_on_next;
            pass_reg     <= pass_next;
            proc_reg     <= proc_next;
            eval_vld_reg <= eval_vld_next;
            eval_idx_reg <= eval_idx_next;
            work_reg     <= work_next;
            fin_reg      <= fin_next;
            done_reg     <= done_next;
        end
    end

endmodule

// ===== rtl/bankers_safety_allocator.sv =====
// Top level of the banker's safety allocator: control, checks and commit.
// Depends on bsa_pkg, bsa_ram and bsa_scan.
//
// Usage: an item (kind, proc_index, amount0..2) is taken at a clock edge with
// start high and busy low. Exactly one result (status, avail0..2) follows,
// shown for one cycle with done high; the receiver cannot stall it.
// Totals are written through cfg_wr_en, cfg_index and cfg_wdata while idle;
// the user must keep to this; the block itself does not enforce it. An invalid
// item gives its result in the cycle after acceptance. Declare and release
// items read the process entry from RAM in the lookup state, then give their
// result through the registered done. A request that passes its checks runs
// the safety check, which reads one RAM entry per cycle over NUM_PROC passes
// of NUM_PROC processes before its result. busy is low again in the cycle
// that carries the result, so the next item may be taken there. Reset clears
// claims and holdings through per-entry valid bits and loads the totals with
// 10, 5 and 7 units; the block is ready right after reset.
module bankers_safety_allocator
    import bsa_pkg::*;
#(
    parameter int NUM_PROC   = 8,
    parameter int COUNT_BITS = 8,
    parameter int NUM_TYPES  = 3
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       start,
    input  logic [1:0] kind,
    input  logic [2:0] proc_index,
    input  logic [7:0] amount0,
    input  logic [7:0] amount1,
    input  logic [7:0] amount2,
    output logic       busy,
    output logic       done,
    output logic [2:0] status,
    output logic [7:0] avail0,
    output logic [7:0] avail1,
    output logic [7:0] avail2
);

    localparam int AW        = $clog2(NUM_PROC);
    localparam int CB        = COUNT_BITS;
    localparam int WW        = (CB > 8) ? CB : 8;
    localparam int COUNT_MAX = (1 << CB) - 1;
    localparam int ENTRY_W   = 2 * NUM_TYPES * CB;

    function automatic logic [CB-1:0] sat_count(input logic [7:0] v);
        logic [WW-1:0] ext;
        ext = WW'(v);
        if (ext > WW'(COUNT_MAX))
        begin
            return CB'(COUNT_MAX);
        end
        return ext[CB-1:0];
    endfunction

    function automatic logic [CB-1:0] free_of(input logic [CB-1:0] total,
                                              input logic [CB-1:0] sum);
        return (sum > total) ? '0 : total - sum;
    endfunction

    state_t                        state_reg, state_next;
    logic [1:0]                    kind_reg, kind_next;
    logic [AW-1:0]                 pidx_reg, pidx_next;
    logic [NUM_TYPES-1:0][CB-1:0]  amt_reg, amt_next;
    logic [NUM_TYPES-1:0][CB-1:0]  total_reg;
    logic [NUM_TYPES-1:0][CB-1:0]  sum_reg, sum_next;
    logic [NUM_PROC-1:0]           valid_reg, valid_next;
    logic                          rd_vld_reg;
    logic [ENTRY_W-1:0]            tent_reg, tent_next;
    logic                          done_reg, done_next;
    logic [2:0]                    status_reg, status_next;
    logic [NUM_TYPES-1:0][CB-1:0]  avail_reg;

    logic [2:0][7:0]               amt_raw;
    logic [NUM_TYPES-1:0][CB-1:0]  amt_in;
    logic [NUM_TYPES-1:0][CB-1:0]  free_now;
    logic [NUM_TYPES-1:0][CB-1:0]  look_claim;
    logic [NUM_TYPES-1:0][CB-1:0]  look_hold;
    logic [NUM_TYPES-1:0][CB-1:0]  tent_hold;
    logic [NUM_TYPES-1:0][CB-1:0]  work_init;
    logic [ENTRY_W-1:0]            ram_q;
    logic [ENTRY_W-1:0]            rd_word;
    logic [ENTRY_W-1:0]            ram_wdata;
    logic                          ram_we;
    logic [AW-1:0]                 ram_raddr;
    logic [AW-1:0]                 scan_addr;
    logic                          scan_start;
    scan_stat_t                    scan_stat;
    logic                          accept;
    logic                          proc_ok;
    logic                          chk_ok;
    logic                          over_claim;
    logic                          over_avail;

    assign amt_raw = {amount2, amount1, amount0};
    assign accept  = start && (state_reg == S_IDLE);
    assign proc_ok = int'(proc_index) < NUM_PROC;
    assign rd_word = rd_vld_reg ? ram_q : '0;
    assign ram_raddr = (state_reg == S_IDLE) ? AW'(proc_index) : scan_addr;

    always_comb
    begin
        for (int t = 0; t < NUM_TYPES; t++)
        begin
            amt_in[t]     = sat_count(amt_raw[t]);
            free_now[t]   = free_of(total_reg[t], sum_reg[t]);
            look_claim[t] = rd_word[t*CB +: CB];
            look_hold[t]  = rd_word[(NUM_TYPES+t)*CB +: CB];
            tent_hold[t]  = tent_reg[(NUM_TYPES+t)*CB +: CB];
            work_init[t]  = free_now[t] - amt_reg[t];
        end
    end

    bsa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_PROC)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pidx_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    bsa_scan #(
        .NUM_PROC   (NUM_PROC),
        .COUNT_BITS (COUNT_BITS),
        .NUM_TYPES  (NUM_TYPES)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (scan_start),
        .work_init (work_init),
        .tent_idx  (pidx_reg),
        .tent_hold (tent_hold),
        .rd_word   (rd_word),
        .rd_addr   (scan_addr),
        .stat      (scan_stat)
    );

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        pidx_next   = pidx_reg;
        amt_next    = amt_reg;
        sum_next    = sum_reg;
        valid_next  = valid_reg;
        tent_next   = tent_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_wdata   = tent_reg;
        scan_start  = 1'b0;
        chk_ok      = 1'b1;
        over_claim  = 1'b0;
        over_avail  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next = kind;
                    pidx_next = AW'(proc_index);
                    amt_next  = amt_in;
                    if (proc_ok && (kind == KIND_DECLARE || kind == KIND_REQUEST ||
                                    kind == KIND_RELEASE))
                    begin
                        state_next = S_LOOKUP;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        status_next = ST_INVALID;
                    end
                end
            end

            S_LOOKUP:
            begin
                state_next = S_IDLE;
                case (kind_reg)
                    KIND_DECLARE:
                    begin
                        for (int t = 0; t < NUM_TYPES; t++)
                        begin
                            if (amt_reg[t] < look_hold[t] || amt_reg[t] > total_reg[t])
                            begin
                                chk_ok = 1'b0;
                            end
                            ram_wdata[t*CB +: CB]             = amt_reg[t];
                            ram_wdata[(NUM_TYPES+t)*CB +: CB] = look_hold[t];
                        end
                        done_next   = 1'b1;
                        status_next = chk_ok ? ST_DONE : ST_INVALID;
                        if (chk_ok)
                        begin
                            ram_we               = 1'b1;
                            valid_next[pidx_reg] = 1'b1;
                        end
                    end

                    KIND_RELEASE:
                    begin
                        for (int t = 0; t < NUM_TYPES; t++)
                        begin
                            if (amt_reg[t] > look_hold[t])
                            begin
                                chk_ok = 1'b0;
                            end
                            ram_wdata[t*CB +: CB]             = look_claim[t];
                            ram_wdata[(NUM_TYPES+t)*CB +: CB] = look_hold[t] - amt_reg[t];
                        end
                        done_next   = 1'b1;
                        status_next = chk_ok ? ST_DONE : ST_INVALID;
                        if (chk_ok)
                        begin
                            ram_we               = 1'b1;
                            valid_next[pidx_reg] = 1'b1;
                            for (int t = 0; t < NUM_TYPES; t++)
                            begin
                                sum_next[t] = sum_reg[t] - amt_reg[t];
                            end
                        end
                    end

                    default:
                    begin
                        for (int t = 0; t < NUM_TYPES; t++)
                        begin
                            if (amt_reg[t] > (look_claim[t] - look_hold[t]))
                            begin
                                over_claim = 1'b1;
                            end
                            if (amt_reg[t] > free_now[t])
                            begin
                                over_avail = 1'b1;
                            end
                            tent_next[t*CB +: CB]             = look_claim[t];
                            tent_next[(NUM_TYPES+t)*CB +: CB] = look_hold[t] + amt_reg[t];
                        end
                        if (over_claim)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_OVER_CLAIM;
                        end
                        else if (over_avail)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_OVER_AVAIL;
                        end
                        else
                        begin
                            scan_start = 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                endcase
            end

            S_SCAN:
            begin
                if (scan_stat.done)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    if (scan_stat.safe)
                    begin
                        status_next          = ST_GRANTED;
                        ram_we               = 1'b1;
                        valid_next[pidx_reg] = 1'b1;
                        for (int t = 0; t < NUM_TYPES; t++)
                        begin
                            sum_next[t] = sum_reg[t] + amt_reg[t];
                        end
                    end
                    else
                    begin
                        status_next = ST_UNSAFE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            kind_reg   <= KIND_DECLARE;
            pidx_reg   <= '0;
            sum_reg    <= '0;
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
            status_reg <= ST_DONE;
            for (int t = 0; t < NUM_TYPES; t++)
            begin
                total_reg[t] <= sat_count(TOTAL_RESET[t]);
            end
        end
        else
        begin
            state_reg  <= state_next;
            kind_reg   <= kind_next;
            pidx_reg   <= pidx_next;
            sum_reg    <= sum_next;
            valid_reg  <= valid_next;
            rd_vld_reg <= valid_reg[ram_raddr];
            done_reg   <= done_next;
            status_reg <= status_next;
            if (cfg_wr_en)
            begin
                for (int t = 0; t < NUM_TYPES; t++)
                begin
                    if (cfg_index == 2'(t))
                    begin
                        total_reg[t] <= sat_count(cfg_wdata);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        amt_reg  <= amt_next;
        tent_reg <= tent_next;
        if (done_next)
        begin
            for (int t = 0; t < NUM_TYPES; t++)
            begin
                avail_reg[t] <= free_of(total_reg[t], sum_next[t]);
            end
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;

    logic [2:0][7:0] avail_out;

    for (genvar g = 0; g < MAX_TYPES; g++)
    begin : g_avail
        if (g < NUM_TYPES)
        begin : g_used
            assign avail_out[g] = 8'(avail_reg[g]);
        end
        else
        begin : g_unused
            assign avail_out[g] = 8'd0;
        end
    end

    assign avail0 = avail_out[0];
    assign avail1 = avail_out[1];
    assign avail2 = avail_out[2];

endmodule
